// ----- src/mldu_pkg.sv -----
// Package for the mouse-look direction unit: item structs, sequencer states,
// register indexes, reset values and the constant tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mldu_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_CORDIC_STEPS  = 16;
  localparam int unsigned DEF_DIR_FRAC_BITS = 14;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = CFG_IDX_W'(1);

  // Reset values
  localparam logic        [15:0] SENS_RESET    = 16'd6554;
  localparam logic        [14:0] PLIM_RESET    = 15'd22784;
  localparam logic signed [15:0] PREV_X_RESET  = 16'sd400;
  localparam logic signed [15:0] PREV_Y_RESET  = 16'sd300;
  localparam logic        [16:0] YAW_RESET     = 17'd69120;
  localparam logic signed [15:0] PITCH_RESET   = -16'sd23040;

  // Angles are in 1/256 degree
  localparam logic [14:0] PITCH_MAX        = 15'd23040;   // 90 degrees
  localparam logic [24:0] YAW_WRAP_OFFSET  = 25'd23592960; // 256 full turns
  localparam int unsigned ANG_DIV          = 45;
  localparam logic [16:0] RECIP_45         = 17'd93207;   // ceil(2^22 / 45)

  // CORDIC, Q2.30
  localparam logic signed [33:0] GAIN_Q30      = 34'sd652032874;
  localparam logic signed [32:0] QUARTER_TURN  = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN     = 33'sd2147483648;
  localparam int unsigned        CORDIC_TBL_LEN = 24;

  localparam logic [29:0] ATAN_TBL [CORDIC_TBL_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  // Fraction part of a binary angle: round((rm * 2^24) / 360) for rm < 45,
  // with the multiple of 45 handled by the quotient bits.
  typedef logic [ANG_DIV-1:0][20:0] ba_frac_tbl_t;

  function automatic ba_frac_tbl_t ba_frac_build();
    ba_frac_tbl_t tbl;
    for (int i = 0; i < ANG_DIV; i++) begin
      tbl[i] = 21'((longint'(i) * 64'd2097152 + 64'd22) / ANG_DIV);
    end
    return tbl;
  endfunction

  localparam ba_frac_tbl_t BA_FRAC_TBL = ba_frac_build();

  typedef struct packed {
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
  } mldu_in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               pitch_clamped;
  } mldu_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_WRAP,
    ST_YAW,
    ST_ANG_P,
    ST_ANG_Y,
    ST_ROT_Y,
    ST_LOAD_P,
    ST_ROT_P,
    ST_MUL_X,
    ST_MUL_Z,
    ST_DONE
  } mldu_state_e;

endpackage

`default_nettype wire

// ----- src/mouse_look_direction_unit.sv -----
// Mouse-look direction unit: pointer samples in, unit view direction out.
// Depends on mldu_pkg. A new sample is taken only in idle, after the result of the
// last one has gone to the output register; each item makes two passes through
// the one CORDIC stage and uses the shared 32x32 multiplier.
// Reset: registers to defaults, yaw 270 deg, pitch -90 deg, first-sample flag
// set; no clearing pass, block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module mouse_look_direction_unit import mldu_pkg::*; #(
  parameter int unsigned CORDIC_STEPS  = DEF_CORDIC_STEPS,
  parameter int unsigned DIR_FRAC_BITS = DEF_DIR_FRAC_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // sample channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mldu_in_t             in_item_i,
  // direction channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mldu_out_t                 out_item_o,
  // register writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i
);

  localparam int unsigned STEP_W      = $clog2(CORDIC_STEPS);
  localparam int unsigned TBL_IDX_W   = $clog2(CORDIC_TBL_LEN);
  localparam int unsigned FIELD_SHIFT = 30 - DIR_FRAC_BITS;
  localparam logic signed [35:0] FIELD_RND = 36'((64'd1 << FIELD_SHIFT) >> 1);
  localparam logic signed [35:0] FIELD_LIM = 36'(64'd1 << DIR_FRAC_BITS);

  // Q2.30 to output field: round half up, saturate, keep 16 bits
  function automatic logic [15:0] to_field(logic signed [33:0] v);
    logic signed [35:0] w;
    w = (36'(v) + FIELD_RND) >>> FIELD_SHIFT;
    if (w > FIELD_LIM) begin
      w = FIELD_LIM;
    end else if (w < -FIELD_LIM) begin
      w = -FIELD_LIM;
    end
    return w[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  mldu_state_e state_q, state_d;

  // architectural state
  logic        [15:0] sens_q, sens_d;
  logic        [14:0] plim_q, plim_d;
  logic signed [15:0] prev_x_q, prev_x_d;
  logic signed [15:0] prev_y_q, prev_y_d;
  logic        [16:0] yaw_q, yaw_d;       // 0 .. 92159
  logic signed [15:0] pitch_q, pitch_d;
  logic               first_q, first_d;
  logic               out_valid_q, out_valid_d;

  // working registers
  logic signed [16:0] dx_q, dx_d;
  logic signed [16:0] dy_q, dy_d;
  logic        [24:0] wrap_q, wrap_d;     // yaw sum made non-negative
  logic               clamp_q, clamp_d;
  logic signed [32:0] ang_p_q, ang_p_d;   // pitch binary angle
  logic signed [33:0] x_q, x_d;
  logic signed [33:0] y_q, y_d;
  logic signed [32:0] z_q, z_d;
  logic               flip_q, flip_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic signed [31:0] cy_q, cy_d;
  logic signed [31:0] sy_q, sy_d;
  logic signed [31:0] cp_q, cp_d;
  logic        [15:0] dir_x_q, dir_x_d;
  logic        [15:0] dir_y_q, dir_y_d;
  logic signed [63:0] p_q, p_d;
  mldu_out_t          out_q, out_d;

  // ---------------------------------------------------------------------------
  // Shared multiplier, result registered in p_q
  // ---------------------------------------------------------------------------
  logic signed [31:0] mul_a, mul_b;
  assign p_d = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Datapath pieces fed from p_q
  // ---------------------------------------------------------------------------
  logic signed [16:0] px, py;
  logic signed [63:0] prod_rnd;
  logic signed [25:0] delta;             // pixels * sensitivity, 1/256 deg
  logic signed [26:0] wrap_sum, wrap_adj;
  logic        [13:0] wrap_hi;
  logic        [7:0]  wrap_quo;
  logic        [13:0] wrap_rem;
  logic        [16:0] yaw_new;
  logic        [14:0] lim;
  logic signed [26:0] lim_s;
  logic signed [26:0] pitch_diff;
  logic        [15:0] pitch_mag;
  logic        [16:0] ba_mag;
  logic        [10:0] ba_quo;
  logic        [16:0] ba_rem_full;
  logic        [5:0]  ba_rem;
  logic        [31:0] ba_r;
  logic signed [32:0] ang_pitch, ang_yaw;
  logic signed [32:0] fold_in, fold_z;
  logic               fold_flip;
  logic signed [33:0] sh_x, sh_y;
  logic signed [32:0] atan_v;
  logic               rot_last;
  logic signed [33:0] rot_c, rot_s;
  logic signed [63:0] q30_rnd;
  logic signed [33:0] q30;

  assign px = 17'(in_item_i.pointer_x);
  assign py = 17'(in_item_i.pointer_y);

  // round half up then floor shift by 8
  assign prod_rnd = p_q + 64'sd128;
  assign delta    = prod_rnd[33:8];

  // yaw wrap: make the sum non-negative with 256 turns, then take it mod
  // 92160 = 45 * 2^11 via a reciprocal multiply on the upper bits
  assign wrap_sum = $signed({10'b0, yaw_q}) + 27'(delta);
  assign wrap_adj = wrap_sum[26] ? wrap_sum + $signed({2'b0, YAW_WRAP_OFFSET}) : wrap_sum;
  assign wrap_hi  = wrap_q[24:11];
  assign wrap_quo = p_q[29:22];
  assign wrap_rem = wrap_hi - 14'(14'(wrap_quo) * 14'(ANG_DIV));
  assign yaw_new  = {wrap_rem[5:0], wrap_q[10:0]};

  // pitch update and clamp; limits above 90 degrees act as 90
  assign lim        = (plim_q > PITCH_MAX) ? PITCH_MAX : plim_q;
  assign lim_s      = $signed({12'b0, lim});
  assign pitch_diff = 27'(pitch_q) - 27'(delta);
  assign pitch_mag  = pitch_q[15] ? 16'(-pitch_q) : pitch_q;

  // binary angle, 2^32 per turn: round(mag * 2^24 / 360)
  // = (mag div 45) << 21 + table(mag mod 45)
  assign ba_mag      = (state_q == ST_ANG_P) ? {1'b0, pitch_mag} : yaw_q;
  assign ba_quo      = p_q[32:22];
  assign ba_rem_full = ba_mag - 17'(17'(ba_quo) * 17'(ANG_DIV));
  assign ba_rem      = ba_rem_full[5:0];
  assign ba_r        = {ba_quo, BA_FRAC_TBL[ba_rem]};

  assign ang_pitch = pitch_q[15] ? -$signed({1'b0, ba_r}) : $signed({1'b0, ba_r});
  // yaw above half a turn maps to the negative side
  assign ang_yaw   = (ba_r > 32'h8000_0000) ? $signed({1'b1, ba_r}) : $signed({1'b0, ba_r});

  // fold into +/- a quarter turn, negate the result afterwards
  assign fold_in = (state_q == ST_LOAD_P) ? ang_p_q : ang_yaw;

  always_comb begin
    if (fold_in > QUARTER_TURN) begin
      fold_z    = fold_in - HALF_TURN;
      fold_flip = 1'b1;
    end else if (fold_in < -QUARTER_TURN) begin
      fold_z    = fold_in + HALF_TURN;
      fold_flip = 1'b1;
    end else begin
      fold_z    = fold_in;
      fold_flip = 1'b0;
    end
  end

  // one CORDIC micro-rotation per cycle, floor shifts
  assign sh_x     = x_q >>> cnt_q;
  assign sh_y     = y_q >>> cnt_q;
  assign atan_v   = $signed({3'b0, ATAN_TBL[TBL_IDX_W'(cnt_q)]});
  assign rot_last = (cnt_q == STEP_W'(CORDIC_STEPS - 1));
  assign rot_c    = flip_q ? -x_q : x_q;
  assign rot_s    = flip_q ? -y_q : y_q;

  // Q2.30 product back to Q2.30, half up
  assign q30_rnd = p_q + (64'sd1 <<< 29);
  assign q30     = q30_rnd[63:30];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    sens_d      = sens_q;
    plim_d      = plim_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    yaw_d       = yaw_q;
    pitch_d     = pitch_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    wrap_d      = wrap_q;
    clamp_d     = clamp_q;
    ang_p_d     = ang_p_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    flip_d      = flip_q;
    cnt_d       = cnt_q;
    cy_d        = cy_q;
    sy_d        = sy_q;
    cp_d        = cp_q;
    dir_x_d     = dir_x_q;
    dir_y_d     = dir_y_q;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    in_ready_o  = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSITIVITY: sens_d = cfg_data_i;
        CFG_PITCH_LIMIT: plim_d = cfg_data_i[14:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // first sample after reset has zero deltas
          dx_d     = first_q ? '0 : px - 17'(prev_x_q);
          dy_d     = first_q ? '0 : py - 17'(prev_y_q);
          prev_x_d = in_item_i.pointer_x;
          prev_y_d = in_item_i.pointer_y;
          first_d  = 1'b0;
          state_d  = ST_MUL_DX;
        end
      end

      ST_MUL_DX: begin
        mul_a   = 32'(dx_q);
        mul_b   = $signed({16'b0, sens_q});
        state_d = ST_MUL_DY;
      end

      ST_MUL_DY: begin
        mul_a   = 32'(dy_q);
        mul_b   = $signed({16'b0, sens_q});
        wrap_d  = wrap_adj[24:0];
        state_d = ST_WRAP;
      end

      ST_WRAP: begin
        mul_a = $signed({18'b0, wrap_hi});
        mul_b = $signed({15'b0, RECIP_45});
        if (pitch_diff > lim_s) begin
          pitch_d = $signed({1'b0, lim});
          clamp_d = 1'b1;
        end else if (pitch_diff < -lim_s) begin
          pitch_d = -$signed({1'b0, lim});
          clamp_d = 1'b1;
        end else begin
          pitch_d = pitch_diff[15:0];
          clamp_d = 1'b0;
        end
        state_d = ST_YAW;
      end

      ST_YAW: begin
        yaw_d   = yaw_new;
        mul_a   = $signed({16'b0, pitch_mag});
        mul_b   = $signed({15'b0, RECIP_45});
        state_d = ST_ANG_P;
      end

      ST_ANG_P: begin
        ang_p_d = ang_pitch;
        mul_a   = $signed({15'b0, yaw_q});
        mul_b   = $signed({15'b0, RECIP_45});
        state_d = ST_ANG_Y;
      end

      ST_ANG_Y: begin
        x_d     = GAIN_Q30;
        y_d     = '0;
        z_d     = fold_z;
        flip_d  = fold_flip;
        cnt_d   = '0;
        state_d = ST_ROT_Y;
      end

      ST_ROT_Y, ST_ROT_P: begin
        if (!z_q[32]) begin
          x_d = x_q - sh_y;
          y_d = y_q + sh_x;
          z_d = z_q - atan_v;
        end else begin
          x_d = x_q + sh_y;
          y_d = y_q - sh_x;
          z_d = z_q + atan_v;
        end
        cnt_d = cnt_q + STEP_W'(1);
        if (rot_last) begin
          state_d = (state_q == ST_ROT_Y) ? ST_LOAD_P : ST_MUL_X;
        end
      end

      ST_LOAD_P: begin
        cy_d    = rot_c[31:0];
        sy_d    = rot_s[31:0];
        x_d     = GAIN_Q30;
        y_d     = '0;
        z_d     = fold_z;
        flip_d  = fold_flip;
        cnt_d   = '0;
        state_d = ST_ROT_P;
      end

      ST_MUL_X: begin
        cp_d    = rot_c[31:0];
        dir_y_d = to_field(rot_s);
        mul_a   = cy_q;
        mul_b   = rot_c[31:0];
        state_d = ST_MUL_Z;
      end

      ST_MUL_Z: begin
        dir_x_d = to_field(q30);
        mul_a   = sy_q;
        mul_b   = cp_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold the z product while the output register is still full
        mul_a = sy_q;
        mul_b = cp_q;
        if (!out_valid_q || out_ready_i) begin
          out_d.dir_x         = dir_x_q;
          out_d.dir_y         = dir_y_q;
          out_d.dir_z         = to_field(q30);
          out_d.pitch_clamped = clamp_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sens_q      <= SENS_RESET;
      plim_q      <= PLIM_RESET;
      prev_x_q    <= PREV_X_RESET;
      prev_y_q    <= PREV_Y_RESET;
      yaw_q       <= YAW_RESET;
      pitch_q     <= PITCH_RESET;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sens_q      <= sens_d;
      plim_q      <= plim_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      yaw_q       <= yaw_d;
      pitch_q     <= pitch_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    wrap_q  <= wrap_d;
    clamp_q <= clamp_d;
    ang_p_q <= ang_p_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    flip_q  <= flip_d;
    cnt_q   <= cnt_d;
    cy_q    <= cy_d;
    sy_q    <= sy_d;
    cp_q    <= cp_d;
    dir_x_q <= dir_x_d;
    dir_y_q <= dir_y_d;
    p_q     <= p_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- src/mldu_checker.sv -----
// Port-level checks for the mouse-look direction unit, bound to the top level.
// Depends on mldu_pkg and mouse_look_direction_unit.
`timescale 1ns / 1ps
`default_nettype none

module mldu_checker import mldu_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire mldu_out_t out_item_i
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed or dropped while stalled");

  // an accepted item keeps the block busy for its work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("block ready again too soon after an item");

  // a new result appears just as the block goes idle after being busy
  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i && $past(!in_ready_i))
    else $error("result appeared outside the end of an item");

  // no result in the cycle straight after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result raised right after accept");

endmodule

bind mouse_look_direction_unit mldu_checker u_mldu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire
